// File: hdl/cfosu_pkg.sv
// Shared constants, types and helpers for the two-body force pipeline.
// No dependencies; every other file of the block imports this package.
package cfosu_pkg;

    // Input position width and derived internal widths
    localparam int POSITION_WIDTH = 20;
    localparam int DIFF_WIDTH     = POSITION_WIDTH + 1;
    localparam int MAG_WIDTH      = 20;
    localparam int SQ_WIDTH       = 2 * MAG_WIDTH;
    localparam int Q_WIDTH        = SQ_WIDTH + 2;
    localparam int ROOT_STAGES    = Q_WIDTH / 2;
    localparam int S_WIDTH        = ROOT_STAGES + 1;
    localparam int Q_LO_WIDTH     = Q_WIDTH / 2;
    localparam int PROD_WIDTH     = Q_LO_WIDTH + S_WIDTH;
    localparam int DEN_WIDTH      = 64;
    localparam int NUM_WIDTH      = 64;
    localparam int QUO_WIDTH      = 24;
    localparam int WIDE_WIDTH     = DEN_WIDTH + QUO_WIDTH;
    localparam int MAGR_WIDTH     = QUO_WIDTH + 1;
    localparam int FORCE_WIDTH    = 24;
    localparam int RADIUS_WIDTH   = 16;
    localparam int LIM_WIDTH      = RADIUS_WIDTH + 1;
    localparam int LIMSQ_WIDTH    = 2 * LIM_WIDTH;

    // Force law constants
    localparam int FAR_GAIN       = 1200;
    localparam int FAR_SHIFT      = 32;
    localparam int GAIN_WIDTH     = 11;
    localparam int NF_WIDTH       = MAG_WIDTH + GAIN_WIDTH;
    localparam int SPRING_SHIFT   = 7;
    localparam int SPRING_DIV     = 5;
    localparam int RADIUS_RESET   = 3072;

    // Register map (index taken from paddr bit 2)
    localparam int  ADDR_WIDTH    = 3;
    localparam logic REG_RADIUS   = 1'b0;
    localparam logic REG_CHARGE   = 1'b1;

    typedef logic [MAG_WIDTH-1:0] mag_t;

    // Per-item information carried alongside the root and divider work
    typedef struct packed {
        mag_t [2:0] a;
        logic [2:0] neg;
        logic       overlap;
        logic       zero;
    } item_t;

    // Per-axis side information through the divider
    typedef struct packed {
        logic neg;
        logic overlap;
        logic zero;
    } side_t;

    // Signed, saturated force word from a magnitude and a sign
    function automatic logic [FORCE_WIDTH-1:0] sat_force(
        input logic [MAGR_WIDTH-1:0] mag,
        input logic                  neg
    );
        logic [FORCE_WIDTH-1:0] res;
        if (neg) begin
            if (mag > MAGR_WIDTH'(1 << (FORCE_WIDTH - 1)))
                res = {1'b1, {(FORCE_WIDTH-1){1'b0}}};
            else
                res = FORCE_WIDTH'(~mag + 1'b1);
        end else begin
            if (mag > MAGR_WIDTH'((1 << (FORCE_WIDTH - 1)) - 1))
                res = {1'b0, {(FORCE_WIDTH-1){1'b1}}};
            else
                res = mag[FORCE_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/coulomb_force_with_overlap_spring_unit.sv
// Throughput: one word per cycle unless the output stalls; the root and
// divider are fully pipelined, one root bit and one quotient bit per stage.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n, asynchronous, active low) clears all valid bits and loads
// sphere_radius = 3072 and charge_negative = 0.
module coulomb_force_with_overlap_spring_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z (20 bits each)
    input  logic [6*cfosu_pkg::POSITION_WIDTH-1:0] s_tdata,
    // Output stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // force_one_x, force_one_y, force_one_z, force_two_x, force_two_y,
    // force_two_z (24 bits each)
    output logic [6*cfosu_pkg::FORCE_WIDTH-1:0]   m_tdata,
    // overlapping
    output logic                                  m_tuser,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [cfosu_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import cfosu_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int FW = FORCE_WIDTH;

    logic [RADIUS_WIDTH-1:0] radius_reg;
    logic                    charge_reg;
    logic                    en;

    logic                    fr_valid;
    item_t                   fr_item;
    logic [Q_WIDTH-1:0]      fr_q;

    logic                    sq_valid;
    item_t                   sq_item;
    logic [Q_WIDTH-1:0]      sq_q;
    logic [S_WIDTH-1:0]      sq_s;

    logic                    d1_valid_reg, d2_valid_reg;
    item_t                   d1_item_reg, d2_item_reg;
    logic [PROD_WIDTH-1:0]   plo_reg, phi_reg;
    logic [NF_WIDTH-1:0]     nf_reg [3];
    logic [NUM_WIDTH-1:0]    num_reg [3];
    logic [DEN_WIDTH-1:0]    den_reg [3];
    logic [DEN_WIDTH-1:0]    den_far;

    logic [2:0]              dv_valid;
    logic [MAGR_WIDTH-1:0]   dv_mag [3];
    side_t                   dv_side [3];

    logic                    out_valid_reg;
    logic [6*FW-1:0]         out_data_reg;
    logic                    out_user_reg;
    logic [6*FW-1:0]         out_data_next;

    // Configuration registers; pready is always high
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_WIDTH'(RADIUS_RESET);
            charge_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_RADIUS: radius_reg <= pwdata[RADIUS_WIDTH-1:0];
                REG_CHARGE: charge_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_RADIUS: prdata = {{(32-RADIUS_WIDTH){1'b0}}, radius_reg};
            REG_CHARGE: prdata = {31'b0, charge_reg};
            default:    prdata = '0;
        endcase
    end

    // The whole pipeline moves whenever the output register can take a word
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    cfosu_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_tvalid),
        .first_x         (s_tdata[0*PW +: PW]),
        .first_y         (s_tdata[1*PW +: PW]),
        .first_z         (s_tdata[2*PW +: PW]),
        .second_x        (s_tdata[3*PW +: PW]),
        .second_y        (s_tdata[4*PW +: PW]),
        .second_z        (s_tdata[5*PW +: PW]),
        .sphere_radius   (radius_reg),
        .charge_negative (charge_reg),
        .out_valid       (fr_valid),
        .out_item        (fr_item),
        .out_q           (fr_q)
    );

    cfosu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_item   (fr_item),
        .in_q      (fr_q),
        .out_valid (sq_valid),
        .out_item  (sq_item),
        .out_q     (sq_q),
        .out_s     (sq_s)
    );

    // Denominator, first half: partial products of Q by the root, far numerators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d1_valid_reg <= sq_valid;
            d2_valid_reg <= d1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg     <= PROD_WIDTH'(sq_q[Q_LO_WIDTH-1:0] * sq_s);
            phi_reg     <= PROD_WIDTH'(sq_q[Q_WIDTH-1:Q_LO_WIDTH] * sq_s);
            d1_item_reg <= sq_item;
            for (int i = 0; i < 3; i++)
            begin
                nf_reg[i] <= NF_WIDTH'(sq_item.a[i] * GAIN_WIDTH'(FAR_GAIN));
            end
        end
    end

    // Denominator, second half: sum the partial products and pick the law
    assign den_far = DEN_WIDTH'({phi_reg, {Q_LO_WIDTH{1'b0}}}) + DEN_WIDTH'(plo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_item_reg <= d1_item_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (d1_item_reg.overlap)
                begin
                    num_reg[i] <= NUM_WIDTH'(d1_item_reg.a[i]) << SPRING_SHIFT;
                    den_reg[i] <= DEN_WIDTH'(SPRING_DIV);
                end
                else
                begin
                    num_reg[i] <= NUM_WIDTH'(nf_reg[i]) << FAR_SHIFT;
                    den_reg[i] <= den_far;
                end
            end
        end
    end

    // One divider per axis
    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        side_t side_in;

        assign side_in.neg     = d2_item_reg.neg[i];
        assign side_in.overlap = d2_item_reg.overlap;
        assign side_in.zero    = d2_item_reg.zero;

        cfosu_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d2_valid_reg),
            .num       (num_reg[i]),
            .den       (den_reg[i]),
            .in_side   (side_in),
            .out_valid (dv_valid[i]),
            .out_mag   (dv_mag[i]),
            .out_side  (dv_side[i])
        );
    end

    // Signs and saturation for both devices
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_data_next[i*FW +: FW] =
                sat_force(dv_mag[i], dv_side[i].neg && (dv_mag[i] != '0));
            out_data_next[(i+3)*FW +: FW] =
                sat_force(dv_mag[i], !dv_side[i].neg && (dv_mag[i] != '0));
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= &dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= dv_side[0].overlap;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: hdl/cfosu_front.sv
// Front stages: difference vector, magnitudes, squared distance and overlap test.
// Depends on cfosu_pkg.
module cfosu_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [cfosu_pkg::POSITION_WIDTH-1:0] first_x,
    input  logic signed [cfosu_pkg::POSITION_WIDTH-1:0] first_y,
    input  logic signed [cfosu_pkg::POSITION_WIDTH-1:0] first_z,
    input  logic signed [cfosu_pkg::POSITION_WIDTH-1:0] second_x,
    input  logic signed [cfosu_pkg::POSITION_WIDTH-1:0] second_y,
    input  logic signed [cfosu_pkg::POSITION_WIDTH-1:0] second_z,
    input  logic [cfosu_pkg::RADIUS_WIDTH-1:0]     sphere_radius,
    input  logic                                   charge_negative,
    output logic                                   out_valid,
    output cfosu_pkg::item_t                       out_item,
    output logic [cfosu_pkg::Q_WIDTH-1:0]          out_q
);
    import cfosu_pkg::*;

    logic signed [DIFF_WIDTH-1:0] d [3];
    logic [DIFF_WIDTH-1:0]        absd [3];
    logic [POSITION_WIDTH-1:0]    fa [3];
    logic [POSITION_WIDTH-1:0]    sb [3];
    logic                         far_next;

    logic                  v1_reg, v2_reg, v3_reg;
    mag_t [2:0]            a1_reg, a2_reg;
    logic [2:0]            pos1_reg, pos2_reg;
    logic                  far1_reg, far2_reg;
    logic [SQ_WIDTH-1:0]   sq_reg [3];
    logic [LIMSQ_WIDTH-1:0] limsq_reg;
    item_t                 item_reg;
    logic [Q_WIDTH-1:0]    q_reg;

    logic [Q_WIDTH-1:0]    q_next;
    logic                  overlap_next;
    logic [LIM_WIDTH-1:0]  lim;

    assign fa[0] = first_x;
    assign fa[1] = first_y;
    assign fa[2] = first_z;
    assign sb[0] = second_x;
    assign sb[1] = second_y;
    assign sb[2] = second_z;

    // Difference and magnitude per axis, and the far flag
    always_comb
    begin
        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]    = DIFF_WIDTH'($signed(fa[i])) - DIFF_WIDTH'($signed(sb[i]));
            absd[i] = d[i][DIFF_WIDTH-1] ? DIFF_WIDTH'(-d[i]) : DIFF_WIDTH'(d[i]);
            if (absd[i][DIFF_WIDTH-1:MAG_WIDTH] != '0)
                far_next = 1'b1;
        end
    end

    // Stage one: magnitudes, signs and the far flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            far1_reg <= far_next;
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i]   <= absd[i][MAG_WIDTH-1:0];
                pos1_reg[i] <= !d[i][DIFF_WIDTH-1] && (d[i] != '0);
            end
        end
    end

    assign lim = {sphere_radius, 1'b0};

    // Stage two: squares of the magnitudes and of the overlap limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SQ_WIDTH'(a1_reg[i] * a1_reg[i]);
            end
            limsq_reg <= LIMSQ_WIDTH'(lim * lim);
            a2_reg    <= a1_reg;
            pos2_reg  <= pos1_reg;
            far2_reg  <= far1_reg;
        end
    end

    // Stage three: squared distance, overlap and the zero-force case
    assign q_next = Q_WIDTH'(sq_reg[0]) + Q_WIDTH'(sq_reg[1]) + Q_WIDTH'(sq_reg[2]);
    assign overlap_next = !far2_reg && (q_next < Q_WIDTH'(limsq_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg            <= q_next;
            item_reg.a       <= a2_reg;
            item_reg.neg     <= pos2_reg ^ {3{charge_negative}};
            item_reg.overlap <= overlap_next;
            item_reg.zero    <= far2_reg || (!overlap_next && (q_next == '0));
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;
    assign out_q     = q_reg;

endmodule

// File: hdl/cfosu_sqrt.sv
// Pipelined square root, one result bit per stage, then rounding to nearest.
// Depends on cfosu_pkg.
module cfosu_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  cfosu_pkg::item_t                in_item,
    input  logic [cfosu_pkg::Q_WIDTH-1:0]   in_q,
    output logic                            out_valid,
    output cfosu_pkg::item_t                out_item,
    output logic [cfosu_pkg::Q_WIDTH-1:0]   out_q,
    output logic [cfosu_pkg::S_WIDTH-1:0]   out_s
);
    import cfosu_pkg::*;

    logic               v_reg  [ROOT_STAGES];
    logic [Q_WIDTH-1:0] x_reg  [ROOT_STAGES];
    logic [Q_WIDTH-1:0] r_reg  [ROOT_STAGES];
    logic [Q_WIDTH-1:0] q_reg  [ROOT_STAGES];
    item_t              it_reg [ROOT_STAGES];

    logic               vr_reg;
    item_t              itr_reg;
    logic [Q_WIDTH-1:0] qr_reg;
    logic [S_WIDTH-1:0] s_reg;
    logic [S_WIDTH-1:0] root;

    // One iteration of the digit-by-digit root per stage
    for (genvar k = 0; k < ROOT_STAGES; k++)
    begin : g_root
        localparam logic [Q_WIDTH-1:0] BIT = Q_WIDTH'(1) << (Q_WIDTH - 2 - 2 * k);

        logic               v_in;
        logic [Q_WIDTH-1:0] x_in, r_in, q_in, trial, x_next, r_next;
        item_t              it_in;

        if (k == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign x_in  = in_q;
            assign r_in  = '0;
            assign q_in  = in_q;
            assign it_in = in_item;
        end
        else
        begin : g_rest
            assign v_in  = v_reg[k-1];
            assign x_in  = x_reg[k-1];
            assign r_in  = r_reg[k-1];
            assign q_in  = q_reg[k-1];
            assign it_in = it_reg[k-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            if (x_in >= trial)
            begin
                x_next = x_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]  <= x_next;
                r_reg[k]  <= r_next;
                q_reg[k]  <= q_in;
                it_reg[k] <= it_in;
            end
        end
    end

    // Round to nearest: step up when the remainder exceeds the root
    assign root = S_WIDTH'(r_reg[ROOT_STAGES-1]) +
                  S_WIDTH'(x_reg[ROOT_STAGES-1] > r_reg[ROOT_STAGES-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
        end
        else if (en)
        begin
            vr_reg <= v_reg[ROOT_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= root;
            qr_reg  <= q_reg[ROOT_STAGES-1];
            itr_reg <= it_reg[ROOT_STAGES-1];
        end
    end

    assign out_valid = vr_reg;
    assign out_item  = itr_reg;
    assign out_q     = qr_reg;
    assign out_s     = s_reg;

endmodule

// File: hdl/cfosu_div.sv
// Pipelined restoring divider with overflow detection and round-half-up result.
// Depends on cfosu_pkg.
module cfosu_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [cfosu_pkg::NUM_WIDTH-1:0]  num,
    input  logic [cfosu_pkg::DEN_WIDTH-1:0]  den,
    input  cfosu_pkg::side_t                 in_side,
    output logic                             out_valid,
    output logic [cfosu_pkg::MAGR_WIDTH-1:0] out_mag,
    output cfosu_pkg::side_t                 out_side
);
    import cfosu_pkg::*;

    logic                 v0_reg, ovf0_reg;
    logic [NUM_WIDTH-1:0] rem0_reg;
    logic [DEN_WIDTH-1:0] den0_reg;
    side_t                side0_reg;

    logic                 v_reg    [QUO_WIDTH];
    logic                 ovf_reg  [QUO_WIDTH];
    logic [NUM_WIDTH-1:0] rem_reg  [QUO_WIDTH];
    logic [DEN_WIDTH-1:0] den_reg  [QUO_WIDTH];
    logic [QUO_WIDTH-1:0] quo_reg  [QUO_WIDTH];
    side_t                side_reg [QUO_WIDTH];

    logic                  vo_reg;
    logic [MAGR_WIDTH-1:0] mag_reg;
    side_t                 sideo_reg;

    logic                  round_up;
    logic [MAGR_WIDTH-1:0] mag_next;

    // Quotient would not fit in its bits: the force saturates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf0_reg  <= {{QUO_WIDTH{1'b0}}, num} >= {den, {QUO_WIDTH{1'b0}}};
            rem0_reg  <= num;
            den0_reg  <= den;
            side0_reg <= in_side;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < QUO_WIDTH; k++)
    begin : g_step
        logic                  v_in, ovf_in;
        logic [NUM_WIDTH-1:0]  rem_in;
        logic [DEN_WIDTH-1:0]  den_in;
        logic [QUO_WIDTH-1:0]  quo_in;
        side_t                 side_in;
        logic [WIDE_WIDTH-1:0] dsh, rem_wide;
        logic                  take;

        if (k == 0)
        begin : g_first
            assign v_in    = v0_reg;
            assign ovf_in  = ovf0_reg;
            assign rem_in  = rem0_reg;
            assign den_in  = den0_reg;
            assign quo_in  = '0;
            assign side_in = side0_reg;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign ovf_in  = ovf_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign dsh      = {{QUO_WIDTH{1'b0}}, den_in} << (QUO_WIDTH - 1 - k);
        assign rem_wide = {{QUO_WIDTH{1'b0}}, rem_in};
        assign take     = rem_wide >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? NUM_WIDTH'(rem_wide - dsh) : rem_in;
                quo_reg[k]  <= quo_in | (QUO_WIDTH'(take) << (QUO_WIDTH - 1 - k));
                ovf_reg[k]  <= ovf_in;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    // Round half up, then apply overflow and the zero-force case
    assign round_up = {rem_reg[QUO_WIDTH-1], 1'b0} >= {1'b0, den_reg[QUO_WIDTH-1]};

    always_comb
    begin
        if (side_reg[QUO_WIDTH-1].zero)
            mag_next = '0;
        else if (ovf_reg[QUO_WIDTH-1])
            mag_next = MAGR_WIDTH'(1) << QUO_WIDTH;
        else
            mag_next = MAGR_WIDTH'(quo_reg[QUO_WIDTH-1]) + MAGR_WIDTH'(round_up);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= v_reg[QUO_WIDTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            sideo_reg <= side_reg[QUO_WIDTH-1];
        end
    end

    assign out_valid = vo_reg;
    assign out_mag   = mag_reg;
    assign out_side  = sideo_reg;

endmodule

// File: hdl/cfosu_checker.sv
// Port-level checks of the force unit, attached to the top level by bind.
// Depends on cfosu_pkg and coulomb_force_with_overlap_spring_unit.
module cfosu_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [6*cfosu_pkg::FORCE_WIDTH-1:0]    m_tdata,
    input logic                                   pready
);
    import cfosu_pkg::*;

    logic signed [FORCE_WIDTH:0] sum_x;
    logic signed [FORCE_WIDTH:0] sum_z;

    // Second device force plus first device force is zero, or minus one at saturation
    assign sum_x = $signed({m_tdata[FORCE_WIDTH-1], m_tdata[0 +: FORCE_WIDTH]}) +
                   $signed({m_tdata[4*FORCE_WIDTH-1], m_tdata[3*FORCE_WIDTH +: FORCE_WIDTH]});
    assign sum_z = $signed({m_tdata[3*FORCE_WIDTH-1], m_tdata[2*FORCE_WIDTH +: FORCE_WIDTH]}) +
                   $signed({m_tdata[6*FORCE_WIDTH-1], m_tdata[5*FORCE_WIDTH +: FORCE_WIDTH]});

    // Input side stalls exactly when a waiting output word is not taken
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // A pending output word stays valid until taken
    a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_opposite_x: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (sum_x == 0 || sum_x == -1))
        else $error("x forces of the two devices are not opposite");

    a_opposite_z: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (sum_z == 0 || sum_z == -1))
        else $error("z forces of the two devices are not opposite");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind coulomb_force_with_overlap_spring_unit cfosu_checker u_cfosu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// File: tb/cfosu_force_checker.sv
`timescale 1ns / 1ps
// Checker for the two-body force unit: predicts each output word from the accepted
// input words and the configuration, then compares field by field. Uses cfosu_pkg.
module cfosu_force_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [6*cfosu_pkg::POSITION_WIDTH-1:0] s_tdata,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [6*cfosu_pkg::FORCE_WIDTH-1:0]    m_tdata,
    input  logic                                   m_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cfosu_pkg::ADDR_WIDTH-1:0]       paddr,
    input  logic [31:0]                            pwdata,
    input  logic                                   pready,
    output int                                     fail_count,
    output int                                     pending_count,
    output int                                     word_count
);
    import cfosu_pkg::*;

    typedef struct {
        logic [FORCE_WIDTH-1:0] one [3];
        logic [FORCE_WIDTH-1:0] two [3];
        logic                   overlap;
    } force_word_t;

    force_word_t expected_forces[$];
    logic [15:0] radius_reg;
    logic        charge_neg_reg;

    // Saturated signed field from a magnitude and a sign.
    function automatic logic [FORCE_WIDTH-1:0] clamp_force(longint unsigned mag, bit neg);
        if (neg)
            return (mag > 64'd8388608) ? 24'h800000 : 24'(-mag);
        return (mag > 64'd8388607) ? 24'h7FFFFF : 24'(mag);
    endfunction

    // Force law for one pair of positions under the current configuration.
    function automatic force_word_t compute_forces(logic [6*POSITION_WIDTH-1:0] pos);
        force_word_t fw;
        longint d [3];
        longint unsigned a [3];
        longint unsigned q, lim, s, den, mag;
        bit [127:0] num;
        bit [127:0] qt, rm;
        bit neg;
        q = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'($signed(pos[i*POSITION_WIDTH +: POSITION_WIDTH]))
                 - longint'($signed(pos[(i+3)*POSITION_WIDTH +: POSITION_WIDTH]));
            a[i] = (d[i] < 0) ? -d[i] : d[i];
            q += a[i] * a[i];
            fw.one[i] = '0;
            fw.two[i] = '0;
        end
        lim = 2 * longint'(radius_reg);
        fw.overlap = q < lim * lim;
        if (!fw.overlap && q == 0)
            return fw;
        // Integer square root, rounded to nearest.
        s = 0;
        for (int b = 31; b >= 0; b--)
            if ((s | (64'd1 << b)) * (s | (64'd1 << b)) <= q)
                s |= 64'd1 << b;
        if (q - s * s > s)
            s++;
        den = q * s;
        for (int i = 0; i < 3; i++)
        begin
            neg = (d[i] > 0) != charge_neg_reg;
            if (fw.overlap)
                mag = (128 * a[i]) / 5 + (((128 * a[i]) % 5) >= 3 ? 1 : 0);
            else
            begin
                num = (128'd1200 << 32) * a[i];
                qt = num / den;
                rm = num % den;
                mag = 64'(qt) + ((rm >= den - rm) ? 1 : 0);
            end
            if (mag == 0)
                neg = 0;
            fw.one[i] = clamp_force(mag, neg);
            fw.two[i] = clamp_force(mag, mag != 0 && !neg);
        end
        return fw;
    endfunction

    task automatic report_mismatch(string what, int idx, logic [31:0] got, logic [31:0] want);
        $display("ERROR word %0d: %s got %0h want %0h", idx, what, got, want);
        fail_count++;
    endtask

    // Register writes, input prediction and output comparison.
    always @(posedge clk or negedge rst_n)
    begin
        force_word_t want;
        if (!rst_n)
        begin
            radius_reg     <= 16'd3072;
            charge_neg_reg <= 1'b0;
            fail_count     = 0;
            word_count     = 0;
            pending_count  = 0;
            expected_forces.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_forces.push_back(compute_forces(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_forces.size() == 0)
                begin
                    report_mismatch("unexpected output word", word_count, '0, '0);
                end
                else
                begin
                    want = expected_forces.pop_front();
                    for (int i = 0; i < 3; i++)
                    begin
                        if (m_tdata[i*FORCE_WIDTH +: FORCE_WIDTH] !== want.one[i])
                            report_mismatch($sformatf("force_one[%0d]", i), word_count,
                                m_tdata[i*FORCE_WIDTH +: FORCE_WIDTH], want.one[i]);
                        if (m_tdata[(i+3)*FORCE_WIDTH +: FORCE_WIDTH] !== want.two[i])
                            report_mismatch($sformatf("force_two[%0d]", i), word_count,
                                m_tdata[(i+3)*FORCE_WIDTH +: FORCE_WIDTH], want.two[i]);
                    end
                    if (m_tuser !== want.overlap)
                        report_mismatch("overlapping", word_count, m_tuser, want.overlap);
                end
                word_count++;
            end
            pending_count = expected_forces.size();
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_RADIUS)
                    radius_reg <= pwdata[15:0];
                else
                    charge_neg_reg <= pwdata[0];
            end
        end
    end
endmodule

// File: tb/tb_coulomb_force_with_overlap_spring_unit.sv
`timescale 1ns / 1ps
// Top of the force unit testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on cfosu_pkg, the unit itself and cfosu_force_checker.
module tb_coulomb_force_with_overlap_spring_unit;
    import cfosu_pkg::*;

    localparam int LATENCY = 54;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // first_x, first_y, first_z, second_x, second_y, second_z, from bit 0 up
    logic [6*POSITION_WIDTH-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // force_one_x/y/z then force_two_x/y/z, from bit 0 up
    logic [6*FORCE_WIDTH-1:0] m_tdata;
    // overlapping
    logic m_tuser;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count, pending_count, word_count;
    bit stimulus_done = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    coulomb_force_with_overlap_spring_unit DUT (.*);

    cfosu_force_checker checker_i (.*);

    function automatic int gap_length();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random output stalls, with a stall-free stretch in the middle.
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= 1'b1;
            if (word_count < 300 || word_count > 500)
            begin
                g = gap_length();
                repeat (g) @(negedge clk) m_tready <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic regsel, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {regsel, 2'b00}; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Called at a falling edge; a word follows the previous one directly when no gap is drawn.
    task automatic send_positions(logic [6*POSITION_WIDTH-1:0] pos);
        int g;
        g = gap_length();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Waits until every expected word has arrived, then for the pipeline depth.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [6*POSITION_WIDTH-1:0] pair(
        int fx, int fy, int fz, int sx, int sy, int sz);
        return {20'(sz), 20'(sy), 20'(sx), 20'(fz), 20'(fy), 20'(fx)};
    endfunction

    function automatic int rand_pos();
        return int'($signed(20'($urandom)));
    endfunction

    // Positions whose distance lands near twice the current radius, very close together, or at random.
    function automatic logic [6*POSITION_WIDTH-1:0] random_pair(int radius);
        int bx, by, bz, span;
        bx = rand_pos(); by = rand_pos(); bz = rand_pos();
        case ($urandom_range(0, 3))
            0: return pair(rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos());
            1:
            begin
                span = 4 * radius + 8;
                return pair(bx, by, bz,
                    bx - $urandom_range(0, span) + span / 2,
                    by - $urandom_range(0, span) + span / 2,
                    bz - $urandom_range(0, span) + span / 2);
            end
            2:
            begin
                span = 2 * radius + 1;
                return pair(bx, by, bz, bx - span + $urandom_range(0, 2), by, bz);
            end
            default:
            begin
                span = $urandom_range(1, 64);
                return pair(bx, by, bz, bx + $urandom_range(0, span) - span / 2,
                    by + $urandom_range(0, span) - span / 2, bz);
            end
        endcase
    endfunction

    initial
    begin
        int radii [6] = '{3072, 0, 65535, 1, 300, 3072};
        int maxp, minp;
        maxp = 524287;
        minp = -524288;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset configuration, extremes, overlap edge, coincident points.
        send_positions(pair(0, 0, 0, 0, 0, 0));
        send_positions(pair(maxp, maxp, maxp, minp, minp, minp));
        send_positions(pair(minp, minp, minp, maxp, maxp, maxp));
        send_positions(pair(maxp, 0, 0, minp, 0, 0));
        send_positions(pair(6143, 0, 0, 0, 0, 0));
        send_positions(pair(6144, 0, 0, 0, 0, 0));
        send_positions(pair(0, -6145, 0, 0, 0, 0));
        send_positions(pair(1, 0, 0, 0, 0, 0));
        send_positions(pair(0, 0, 1, 0, 0, 0));
        send_positions(pair(-1, -1, 1, 0, 0, 0));
        send_positions(pair(100, 3, -7, 0, 0, 0));
        send_positions(pair(0, 0, 0, 3, -2, 1));
        drain();
        write_reg(REG_RADIUS, 32'd0);
        write_reg(REG_CHARGE, 32'hFFFF_FFFF);
        send_positions(pair(0, 0, 0, 0, 0, 0));
        send_positions(pair(1, 0, 0, 0, 0, 0));
        send_positions(pair(0, 2, 0, 0, 0, 0));
        send_positions(pair(maxp, maxp, maxp, minp, minp, minp));
        drain();
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        send_positions(pair(maxp, maxp, maxp, minp, minp, minp));
        send_positions(pair(131069, 0, 0, 0, 0, 0));
        send_positions(pair(131071, 0, 0, 0, 0, 0));
        send_positions(pair(-131070, 0, 0, 0, 0, 0));
        drain();

        // Random phases over several configurations.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_RADIUS, 32'(radii[ph]) | ($urandom & 32'hFFFF_0000));
            write_reg(REG_CHARGE, ph[0] ? $urandom | 1 : $urandom & ~32'd1);
            for (int n = 0; n < 190; n++)
                send_positions(random_pair(radii[ph]));
            drain();
        end
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done);
        $display("Covered %0d output words over six radius and charge settings,", word_count);
        $display("including extreme positions, overlap boundaries and coincident points.");
        if (fail_count == 0)
            $display("tb_coulomb_force_with_overlap_spring_unit: PASS");
        else
            $display("tb_coulomb_force_with_overlap_spring_unit: FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d words outstanding.", pending_count);
        $display("tb_coulomb_force_with_overlap_spring_unit: FAIL");
        $finish;
    end
endmodule

// File: sim.f
hdl/cfosu_pkg.sv
hdl/cfosu_front.sv
hdl/cfosu_sqrt.sv
hdl/cfosu_div.sv
hdl/coulomb_force_with_overlap_spring_unit.sv
hdl/cfosu_checker.sv
tb/cfosu_force_checker.sv
tb/tb_coulomb_force_with_overlap_spring_unit.sv
